// ===== rtl/core/skvt_pkg.sv =====
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types for the small key/value table: request kinds and the
// command/status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package skvt_pkg;

  localparam int unsigned KIND_BITS = 3;
  localparam int unsigned POS_BITS  = 8;

  // Code 7 is unused and answers a plain failure.
  typedef enum logic [KIND_BITS-1:0] {
    KIND_INSERT     = 3'd0,
    KIND_UPDATE     = 3'd1,
    KIND_INS_UPD    = 3'd2,
    KIND_ERASE      = 3'd3,
    KIND_CONTAINS   = 3'd4,
    KIND_GET_KEY    = 3'd5,
    KIND_GET_POS    = 3'd6
  } kind_e;

  // Controller -> datapath
  typedef struct packed {
    logic load_req;      // latch request, clear staged result
    logic scan_start;    // restart key sweep at entry 0
    logic scan_step;     // one step of key sweep
    logic shift_start;   // start erase sweep after the hit entry
    logic shift_step;    // one step of erase sweep
    logic pos_read;      // read entry at request position
    logic pos_take;      // take entry read by pos_read
    logic put_new;       // append request key/value, count up
    logic upd_val;       // overwrite value of the hit entry
    logic fill_dec;      // count down after erase
    logic set_ok;        // mark staged result as success
    logic take_hit_val;  // stage value of the hit entry
    logic out_load;      // move staged result to the output register
  } skvt_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    kind_e kind;
    logic  match;        // entry under compare holds the request key
    logic  sweep_end;    // all valid entries visited, nothing pending
    logic  hit;          // last key sweep found the key
    logic  full;
    logic  pos_ok;       // request position below entry count
    logic  out_free;     // output register can take a result this cycle
  } skvt_status_t;

endpackage

// ===== rtl/core/skvt_if.sv =====
// ----------------------------------------------------------------------------
// skvt_if
// Valid/ready channels of the small key/value table: request and response.
// ----------------------------------------------------------------------------
interface skvt_req_if #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            kind;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;
  logic [7:0]            position;

  modport source (output valid, kind, key, value, position, input ready);
  modport sink   (input valid, kind, key, value, position, output ready);
endinterface

interface skvt_rsp_if #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned COUNT_BITS = 9
);
  logic                  valid;
  logic                  ready;
  logic                  ok;
  logic [KEY_BITS-1:0]   found_key;
  logic [VALUE_BITS-1:0] found_value;
  logic [COUNT_BITS-1:0] entry_count;
  logic                  is_empty;

  modport source (output valid, ok, found_key, found_value, entry_count, is_empty,
                  input ready);
  modport sink   (input valid, ok, found_key, found_value, entry_count, is_empty,
                  output ready);
endinterface

// ===== rtl/core/skvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// skvt_ctrl
// Request sequencer: dispatch, key sweep or position read, operation, erase sweep, response.
// ----------------------------------------------------------------------------
module skvt_ctrl import skvt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  skvt_status_t status_i,
  output skvt_cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_DISPATCH = 8'b0000_0010,
    ST_SCAN     = 8'b0000_0100,
    ST_ACT      = 8'b0000_1000,
    ST_SHIFT    = 8'b0001_0000,
    ST_POS_TAKE = 8'b0010_0000,
    ST_RESP     = 8'b0100_0000,
    ST_SPARE    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (status_i.kind)
          KIND_INSERT, KIND_UPDATE, KIND_INS_UPD, KIND_ERASE,
          KIND_CONTAINS, KIND_GET_KEY: begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
          KIND_GET_POS: begin
            if (status_i.pos_ok) begin
              cmd_o.pos_read = 1'b1;
              state_d        = ST_POS_TAKE;
            end else begin
              state_d = ST_RESP;
            end
          end
          default: state_d = ST_RESP;
        endcase
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.match || status_i.sweep_end) begin
          state_d = ST_ACT;
        end
      end
      ST_ACT: begin
        state_d = ST_RESP;
        unique case (status_i.kind)
          KIND_INSERT: begin
            if (!status_i.hit && !status_i.full) begin
              cmd_o.put_new = 1'b1;
              cmd_o.set_ok  = 1'b1;
            end
          end
          KIND_UPDATE: begin
            if (status_i.hit) begin
              cmd_o.upd_val = 1'b1;
              cmd_o.set_ok  = 1'b1;
            end
          end
          KIND_INS_UPD: begin
            if (status_i.hit) begin
              cmd_o.upd_val = 1'b1;
              cmd_o.set_ok  = 1'b1;
            end else if (!status_i.full) begin
              cmd_o.put_new = 1'b1;
              cmd_o.set_ok  = 1'b1;
            end
          end
          KIND_ERASE: begin
            if (status_i.hit) begin
              cmd_o.shift_start = 1'b1;
              state_d           = ST_SHIFT;
            end
          end
          KIND_CONTAINS: begin
            cmd_o.set_ok = status_i.hit;
          end
          KIND_GET_KEY: begin
            cmd_o.set_ok       = status_i.hit;
            cmd_o.take_hit_val = status_i.hit;
          end
          default: ;
        endcase
      end
      ST_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (status_i.sweep_end) begin
          cmd_o.fill_dec = 1'b1;
          cmd_o.set_ok   = 1'b1;
          state_d        = ST_RESP;
        end
      end
      ST_POS_TAKE: begin
        cmd_o.pos_take = 1'b1;
        state_d        = ST_RESP;
      end
      ST_RESP: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/skvt_datapath.sv =====
// ----------------------------------------------------------------------------
// skvt_datapath
// Key and value memories, entry count, sweep pointers, staged result and
// output register.
// ----------------------------------------------------------------------------
module skvt_datapath import skvt_pkg::*; #(
  parameter  int unsigned CAPACITY   = 256,
  parameter  int unsigned KEY_BITS   = 32,
  parameter  int unsigned VALUE_BITS = 32,
  localparam int unsigned CNT_BITS   = $clog2(CAPACITY + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  skvt_cmd_t             cmd_i,
  output skvt_status_t          status_o,
  input  logic [KIND_BITS-1:0]  req_kind_i,
  input  logic [KEY_BITS-1:0]   req_key_i,
  input  logic [VALUE_BITS-1:0] req_value_i,
  input  logic [POS_BITS-1:0]   req_position_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  out_ok_o,
  output logic [KEY_BITS-1:0]   out_found_key_o,
  output logic [VALUE_BITS-1:0] out_found_value_o,
  output logic [CNT_BITS-1:0]   out_entry_count_o,
  output logic                  out_is_empty_o
);

  localparam int unsigned IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CMP_BITS = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

  logic [KEY_BITS-1:0]   key_mem [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem [CAPACITY];

  kind_e                 req_kind_q;
  logic [KEY_BITS-1:0]   req_key_q;
  logic [VALUE_BITS-1:0] req_val_q;
  logic [POS_BITS-1:0]   req_pos_q;

  logic [CNT_BITS-1:0]   fill_q;
  logic [CNT_BITS-1:0]   sidx_q;    // next entry to read
  logic [IDX_BITS-1:0]   cidx_q;    // entry held in the read registers
  logic                  cmp_v_q;   // read registers hold a sweep entry
  logic                  hit_q;
  logic [IDX_BITS-1:0]   slot_q;

  logic [KEY_BITS-1:0]   key_rd_q;
  logic [VALUE_BITS-1:0] val_rd_q;

  logic                  res_ok_q;
  logic [KEY_BITS-1:0]   res_key_q;
  logic [VALUE_BITS-1:0] res_val_q;

  logic                  out_valid_q;
  logic                  out_ok_q;
  logic [KEY_BITS-1:0]   out_key_q;
  logic [VALUE_BITS-1:0] out_val_q;
  logic [CNT_BITS-1:0]   out_cnt_q;
  logic                  out_empty_q;

  logic                  match;
  logic                  more;
  logic                  sweep_end;
  logic                  full;
  logic                  pos_ok;
  logic [CMP_BITS-1:0]   pos_ext;
  logic                  scan_issue;
  logic                  shift_issue;
  logic                  shift_wr;
  logic                  rd_en;
  logic [IDX_BITS-1:0]   rd_addr;
  logic [IDX_BITS-1:0]   wr_addr;
  logic                  key_we;
  logic                  val_we;
  logic [KEY_BITS-1:0]   key_wdata;
  logic [VALUE_BITS-1:0] val_wdata;

  assign match       = cmp_v_q && (key_rd_q == req_key_q);
  assign more        = (sidx_q < fill_q);
  assign sweep_end   = !cmp_v_q && !more;
  assign full        = (fill_q == CNT_BITS'(CAPACITY));
  assign pos_ext     = CMP_BITS'(req_pos_q);
  assign pos_ok      = (pos_ext < CMP_BITS'(fill_q));

  assign scan_issue  = cmd_i.scan_step && !match && more;
  assign shift_issue = cmd_i.shift_step && more;
  assign shift_wr    = cmd_i.shift_step && cmp_v_q;
  assign rd_en       = scan_issue || shift_issue || cmd_i.pos_read;
  assign rd_addr     = cmd_i.pos_read ? pos_ext[IDX_BITS-1:0] : sidx_q[IDX_BITS-1:0];

  assign key_we      = cmd_i.put_new || shift_wr;
  assign val_we      = cmd_i.put_new || cmd_i.upd_val || shift_wr;
  assign key_wdata   = cmd_i.put_new ? req_key_q : key_rd_q;
  assign val_wdata   = (cmd_i.put_new || cmd_i.upd_val) ? req_val_q : val_rd_q;

  always_comb begin
    priority if (cmd_i.put_new) begin
      wr_addr = fill_q[IDX_BITS-1:0];
    end else if (cmd_i.upd_val) begin
      wr_addr = slot_q;
    end else begin
      // erase sweep: entry just read moves down one place
      wr_addr = cidx_q - IDX_BITS'(1);
    end
  end

  always_comb begin
    status_o.kind      = req_kind_q;
    status_o.match     = match;
    status_o.sweep_end = sweep_end;
    status_o.hit       = hit_q;
    status_o.full      = full;
    status_o.pos_ok    = pos_ok;
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

  // memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_wdata;
    end
    if (val_we) begin
      val_mem[wr_addr] <= val_wdata;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[rd_addr];
      val_rd_q <= val_mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      sidx_q      <= '0;
      cmp_v_q     <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.put_new) begin
        fill_q <= fill_q + CNT_BITS'(1);
      end else if (cmd_i.fill_dec) begin
        fill_q <= fill_q - CNT_BITS'(1);
      end

      if (cmd_i.scan_start) begin
        sidx_q  <= '0;
        cmp_v_q <= 1'b0;
        hit_q   <= 1'b0;
      end else if (cmd_i.shift_start) begin
        sidx_q  <= CNT_BITS'(slot_q) + CNT_BITS'(1);
        cmp_v_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        if (match) begin
          hit_q <= 1'b1;
        end else begin
          cmp_v_q <= more;
          if (more) begin
            sidx_q <= sidx_q + CNT_BITS'(1);
          end
        end
      end else if (cmd_i.shift_step) begin
        cmp_v_q <= more;
        if (more) begin
          sidx_q <= sidx_q + CNT_BITS'(1);
        end
      end

      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_kind_q <= kind_e'(req_kind_i);
      req_key_q  <= req_key_i;
      req_val_q  <= req_value_i;
      req_pos_q  <= req_position_i;
    end
    if (scan_issue || shift_issue) begin
      cidx_q <= sidx_q[IDX_BITS-1:0];
    end
    if (cmd_i.scan_step && match) begin
      slot_q <= cidx_q;
    end

    if (cmd_i.load_req) begin
      res_ok_q  <= 1'b0;
      res_key_q <= req_key_i;
      res_val_q <= '0;
    end else begin
      if (cmd_i.set_ok) begin
        res_ok_q <= 1'b1;
      end
      if (cmd_i.take_hit_val) begin
        res_val_q <= val_rd_q;
      end
      if (cmd_i.pos_take) begin
        res_ok_q  <= 1'b1;
        res_key_q <= key_rd_q;
        res_val_q <= val_rd_q;
      end
    end

    if (cmd_i.out_load) begin
      out_ok_q    <= res_ok_q;
      out_key_q   <= res_key_q;
      out_val_q   <= res_val_q;
      out_cnt_q   <= fill_q;
      out_empty_q <= (fill_q == '0);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_ok_o          = out_ok_q;
  assign out_found_key_o   = out_key_q;
  assign out_found_value_o = out_val_q;
  assign out_entry_count_o = out_cnt_q;
  assign out_is_empty_o    = out_empty_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_BITS'(CAPACITY))
    else $error("entry count above capacity");

  a_put_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.put_new |-> !full)
    else $error("append into full table");

  a_dec_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill_dec |-> (fill_q != '0))
    else $error("erase from empty table");

  a_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_wr |-> ((cidx_q != '0) && (CNT_BITS'(cidx_q) < fill_q)))
    else $error("erase move outside valid entries");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

// ===== rtl/core/small_key_value_table.sv =====
// ----------------------------------------------------------------------------
// small_key_value_table
// Fixed-capacity key/value table kept packed in insertion order.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  (sink)   : one transaction per request: kind, key, value, position.
//   rsp_o  (source) : one transaction per request: ok, found_key,
//                     found_value, entry_count, is_empty.
//   A request is taken only while the sequencer is idle; the response of
//   the previous request may still wait in the output register meanwhile.
//   The key sweep and the erase move-down visit one entry a cycle through
//   the single read port of the key/value memories. A new request is taken
//   in the cycle after the previous result loads into the output register.
//   A stalled receiver holds the result in the output register; the next
//   request then waits at its final step until the register is free.
//   Reset empties the table at once (entry count zero); memory contents
//   are never read before they are written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module small_key_value_table import skvt_pkg::*; #(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  skvt_req_if.sink   req_i,
  skvt_rsp_if.source rsp_o
);

  localparam int unsigned CNT_BITS = $clog2(CAPACITY + 1);

  skvt_cmd_t    cmd;
  skvt_status_t status;
  logic         in_ready;

  // sequencer
  skvt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // storage, sweep pointers and result registers
  skvt_datapath #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .req_kind_i        (req_i.kind),
    .req_key_i         (req_i.key),
    .req_value_i       (req_i.value),
    .req_position_i    (req_i.position),
    .out_valid_o       (rsp_o.valid),
    .out_ready_i       (rsp_o.ready),
    .out_ok_o          (rsp_o.ok),
    .out_found_key_o   (rsp_o.found_key),
    .out_found_value_o (rsp_o.found_value),
    .out_entry_count_o (rsp_o.entry_count[CNT_BITS-1:0]),
    .out_is_empty_o    (rsp_o.is_empty)
  );

  assign req_i.ready = in_ready;

endmodule

// ===== bench/small_key_value_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// small_key_value_table_tb
// Drives lookup, write and erase requests into the key/value table and
// checks every response against a typed-in answer or an in-bench copy of the table contents.
// A typed-in directed table comes first, then random traffic on small
// tables, a fill to capacity, work at full and a partial drain.
// ----------------------------------------------------------------------------
module small_key_value_table_tb import skvt_pkg::*;;

  localparam int unsigned CAPACITY       = 256;
  localparam int unsigned POOL_SIZE      = 12;
  localparam int          HOLD_CYCLES    = 300;   // long receiver stall
  localparam int          DRAIN_CYCLES   = 600;   // idle wait once no answer is owed
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam logic [2:0]  KIND_UNUSED    = 3'd7;
  localparam bit          TYPED          = 1'b1;
  localparam bit          PREDICT        = 1'b0;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] key;
    logic [31:0] value;
    logic [7:0]  position;
  } kv_request_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] found_key;
    logic [31:0] found_value;
    logic [8:0]  entry_count;
    logic        is_empty;
  } kv_response_t;

  typedef struct {
    kv_request_t  req;
    bit           typed;
    kv_response_t rsp;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  skvt_req_if #(.KEY_BITS(32), .VALUE_BITS(32)) req_if ();
  skvt_rsp_if #(.KEY_BITS(32), .VALUE_BITS(32), .COUNT_BITS(9)) rsp_if ();

  small_key_value_table #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (32),
    .VALUE_BITS(32)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  // Bench copy of the table: entries 0 .. table_fill-1 are valid, packed in
  // insertion order. Updated at the edge a request transaction is accepted.
  logic [31:0]  table_keys [CAPACITY];
  logic [31:0]  table_vals [CAPACITY];
  int           table_fill;

  kv_response_t table_answers_q [$];   // responses still owed by the DUT
  dir_row_t     dir_rows [$];
  logic [31:0]  key_pool [POOL_SIZE];

  int mismatch_count;
  int quiet_cycles;
  bit gaps_on;            // random idle cycles on both sides
  bit hold_off_pending;   // asks the receiver for one long stall

  // Applies one request to the bench table and returns its response.
  function automatic kv_response_t table_step(kv_request_t r);
    kv_response_t a;
    int           slot;
    a.ok          = 1'b0;
    a.found_key   = r.key;
    a.found_value = '0;
    slot          = -1;
    for (int i = 0; i < table_fill; i++) begin
      if (slot < 0 && table_keys[i] == r.key) slot = i;
    end
    case (r.kind)
      KIND_INSERT: begin
        if (slot < 0 && table_fill < CAPACITY) begin
          table_keys[table_fill] = r.key;
          table_vals[table_fill] = r.value;
          table_fill++;
          a.ok = 1'b1;
        end
      end
      KIND_UPDATE: begin
        if (slot >= 0) begin
          table_vals[slot] = r.value;
          a.ok = 1'b1;
        end
      end
      KIND_INS_UPD: begin
        if (slot >= 0) begin
          table_vals[slot] = r.value;
          a.ok = 1'b1;
        end else if (table_fill < CAPACITY) begin
          table_keys[table_fill] = r.key;
          table_vals[table_fill] = r.value;
          table_fill++;
          a.ok = 1'b1;
        end
      end
      KIND_ERASE: begin
        if (slot >= 0) begin
          // later entries move down one place, order kept
          for (int i = slot; i + 1 < table_fill; i++) begin
            table_keys[i] = table_keys[i+1];
            table_vals[i] = table_vals[i+1];
          end
          table_fill--;
          a.ok = 1'b1;
        end
      end
      KIND_CONTAINS: a.ok = (slot >= 0);
      KIND_GET_KEY: begin
        if (slot >= 0) begin
          a.found_value = table_vals[slot];
          a.ok = 1'b1;
        end
      end
      KIND_GET_POS: begin
        if (int'(r.position) < table_fill) begin
          a.found_key   = table_keys[r.position];
          a.found_value = table_vals[r.position];
          a.ok = 1'b1;
        end
      end
      default: ;  // unused kind: plain failure
    endcase
    a.entry_count = table_fill[8:0];
    a.is_empty    = (table_fill == 0);
    return a;
  endfunction

  // Random request. Keys come from the live table, the small pool (when
  // from_pool is set) or the full 32-bit range.
  function automatic kv_request_t random_request(bit from_pool, int erase_weight);
    kv_request_t r;
    int          pick;
    int          sel;
    r.value = $urandom;
    pick    = $urandom_range(0, 99);
    if (table_fill > 0 && pick < 50)
      r.key = table_keys[$urandom_range(0, table_fill - 1)];
    else if (from_pool && pick < 92)
      r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else
      r.key = $urandom;
    if (table_fill > 0 && $urandom_range(0, 3) != 0)
      r.position = 8'($urandom_range(0, (table_fill > 255) ? 255 : table_fill));
    else
      r.position = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 19);
    if (pick < erase_weight)      r.kind = KIND_ERASE;
    else if (sel < 4)             r.kind = KIND_INSERT;
    else if (sel < 7)             r.kind = KIND_UPDATE;
    else if (sel < 11)            r.kind = KIND_INS_UPD;
    else if (sel < 13)            r.kind = KIND_CONTAINS;
    else if (sel < 15)            r.kind = KIND_GET_KEY;
    else if (sel < 19)            r.kind = KIND_GET_POS;
    else                          r.kind = KIND_UNUSED;
    return r;
  endfunction

  task automatic add_row(input logic [2:0] kind, input logic [31:0] key, value,
                         input logic [7:0] pos, input bit typed, input logic ok,
                         input logic [31:0] fkey, fval, input logic [8:0] cnt);
    dir_row_t row;
    row.req                = '{kind, key, value, pos};
    row.typed              = typed;
    row.rsp                = '{ok, fkey, fval, cnt, (cnt == 0)};
    dir_rows.push_back(row);
  endtask

  // Called right after a falling edge; returns right after the falling
  // edge that follows acceptance. valid stays high between back-to-back
  // transactions, so it gets one assignment per step.
  task automatic send_request(input kv_request_t r, input bit typed,
                              input kv_response_t typed_rsp);
    kv_response_t predicted;
    while (gaps_on && $urandom_range(0, 99) < 28) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.kind     <= r.kind;
    req_if.key      <= r.key;
    req_if.value    <= r.value;
    req_if.position <= r.position;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = table_step(r);
    // directed rows with a typed answer use it; the bench table still steps
    table_answers_q.push_back(typed ? typed_rsp : predicted);
    @(negedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got, want);
    mismatch_count++;
    $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
  endtask

  // Response side: random ready, plus one long hold-off on request.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        rsp_if.ready <= !(gaps_on && $urandom_range(0, 99) < 28);
      end
    end
  end

  // Response check against the oldest owed answer.
  always @(posedge clk_i) begin
    kv_response_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (table_answers_q.size() == 0) begin
        report_mismatch("response with none owed, found_key", rsp_if.found_key, '0);
      end else begin
        want = table_answers_q.pop_front();
        if (rsp_if.ok !== want.ok)
          report_mismatch("ok", 32'(rsp_if.ok), 32'(want.ok));
        if (rsp_if.found_key !== want.found_key)
          report_mismatch("found_key", rsp_if.found_key, want.found_key);
        if (rsp_if.found_value !== want.found_value)
          report_mismatch("found_value", rsp_if.found_value, want.found_value);
        if (rsp_if.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(rsp_if.entry_count), 32'(want.entry_count));
        if (rsp_if.is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(rsp_if.is_empty), 32'(want.is_empty));
      end
    end
  end

  // Watchdog: too long without any transaction on either channel.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", quiet_cycles);
        $display("small_key_value_table: mismatch");
        $finish;
      end
    end
  end

  initial begin
    kv_request_t r;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.kind      = '0;
    req_if.key       = '0;
    req_if.value     = '0;
    req_if.position  = '0;
    table_fill       = 0;
    mismatch_count   = 0;
    quiet_cycles     = 0;
    gaps_on          = 1'b1;
    hold_off_pending = 1'b0;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // -- directed rows: empty table, error answers, extremes, erase shift --
    //       kind           key            value          pos    check    ok fkey fval cnt
    add_row(KIND_CONTAINS, 32'h0,         32'h0,         8'h00, TYPED, 0, 32'h0, 32'h0, 0);
    add_row(KIND_GET_POS,  32'hA5,        32'h0,         8'h00, TYPED, 0, 32'hA5, 32'h0, 0);
    add_row(KIND_UNUSED,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, TYPED, 0,
            32'hFFFF_FFFF, 32'h0, 0);
    add_row(KIND_UPDATE,   32'h1,         32'h2,         8'h00, TYPED, 0, 32'h1, 32'h0, 0);
    add_row(KIND_ERASE,    32'h1,         32'h0,         8'h00, TYPED, 0, 32'h1, 32'h0, 0);
    add_row(KIND_GET_KEY,  32'h1,         32'h0,         8'h00, TYPED, 0, 32'h1, 32'h0, 0);
    add_row(KIND_INSERT,   32'h0,         32'hFFFF_FFFF, 8'h00, TYPED, 1, 32'h0, 32'h0, 1);
    add_row(KIND_INSERT,   32'hFFFF_FFFF, 32'h0,         8'h00, TYPED, 1,
            32'hFFFF_FFFF, 32'h0, 2);
    // duplicate key: refused, table unchanged
    add_row(KIND_INSERT,   32'h0,         32'h1234,      8'h00, TYPED, 0, 32'h0, 32'h0, 2);
    add_row(KIND_GET_KEY,  32'h0,         32'h0,         8'h00, TYPED, 1,
            32'h0, 32'hFFFF_FFFF, 2);
    add_row(KIND_GET_POS,  32'h0,         32'h0,         8'h01, TYPED, 1,
            32'hFFFF_FFFF, 32'h0, 2);
    // position past the end
    add_row(KIND_GET_POS,  32'h5A,        32'h0,         8'hFF, TYPED, 0, 32'h5A, 32'h0, 2);
    add_row(KIND_UPDATE,   32'hFFFF_FFFF, 32'hA5A5_A5A5, 8'h00, PREDICT, 0, 0, 0, 0);
    add_row(KIND_INS_UPD,  32'h0,         32'h5A5A_5A5A, 8'h00, PREDICT, 0, 0, 0, 0);
    add_row(KIND_INS_UPD,  32'h1234_5678, 32'h8765_4321, 8'h00, PREDICT, 0, 0, 0, 0);
    add_row(KIND_CONTAINS, 32'h1234_5678, 32'h0,         8'h00, PREDICT, 0, 0, 0, 0);
    // erase the first entry, the other two move down
    add_row(KIND_ERASE,    32'h0,         32'h0,         8'h00, PREDICT, 0, 0, 0, 0);
    add_row(KIND_GET_POS,  32'h0,         32'h0,         8'h00, PREDICT, 0, 0, 0, 0);
    add_row(KIND_GET_POS,  32'h0,         32'h0,         8'h01, PREDICT, 0, 0, 0, 0);
    add_row(KIND_GET_POS,  32'h0,         32'h0,         8'h02, PREDICT, 0, 0, 0, 0);
    add_row(KIND_GET_KEY,  32'hFFFF_FFFF, 32'h0,         8'h00, PREDICT, 0, 0, 0, 0);
    add_row(KIND_ERASE,    32'hFFFF_FFFF, 32'h0,         8'h00, PREDICT, 0, 0, 0, 0);
    add_row(KIND_ERASE,    32'h1234_5678, 32'h0,         8'h00, PREDICT, 0, 0, 0, 0);
    add_row(KIND_CONTAINS, 32'hFFFF_FFFF, 32'h0,         8'h00, TYPED, 0,
            32'hFFFF_FFFF, 32'h0, 0);
    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

    // -- small tables: keys mostly from a short pool so hits are common --
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    for (int i = 0; i < 480; i++) begin
      if (i == 120) hold_off_pending = 1'b1;   // fills the output side, input stalls
      gaps_on = !(i >= 250 && i < 370);        // one stretch at full rate
      send_request(random_request(1'b1, 20), PREDICT, '0);
    end
    gaps_on = 1'b1;

    // -- fill to capacity with fresh keys (a rare repeat is just refused) --
    while (table_fill < CAPACITY) begin
      r.kind     = KIND_INSERT;
      r.key      = $urandom;
      r.value    = $urandom;
      r.position = 8'($urandom_range(0, 255));
      send_request(r, PREDICT, '0);
    end

    // -- at or near full: new keys refused, erases make room again --
    for (int i = 0; i < 100; i++) send_request(random_request(1'b0, 20), PREDICT, '0);

    // -- partial drain, erase heavy --
    for (int i = 0; i < 60; i++) send_request(random_request(1'b0, 70), PREDICT, '0);

    req_if.valid <= 1'b0;
    while (table_answers_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && table_answers_q.size() == 0)
      $display("small_key_value_table: match");
    else
      $display("small_key_value_table: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/skvt_pkg.sv
rtl/core/skvt_if.sv
rtl/core/skvt_ctrl.sv
rtl/core/skvt_datapath.sv
rtl/core/small_key_value_table.sv
bench/small_key_value_table_tb.sv
